// ----- hdl/rau_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types, commands and controller states.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SUM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic prod;
        logic sum;
        logic gcd_step;
        logic div_start;
        logic div_den;
        logic div_step;
    } t_ctrl;

    typedef struct packed {
        logic bad;
        logic num_zero;
        logic gcd_done;
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic [RES_NUM_W-1:0] result_num;
        logic [RES_DEN_W-1:0] result_den;
        logic                 bad_operand;
    } t_out;

endpackage : rau_pkg
`default_nettype wire

// ----- hdl/rational_arithmetic_unit_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit core
// Adds, subtracts, multiplies or divides two signed fractions and reduces.
// ----------------------------------------------------------------------------
// One request at a time. After acceptance a request forms the products,
// then the sum, then binary GCD steps until r_ga is zero (their number
// is set by the bit lengths of the magnitudes), then two restoring
// divisions on the shared divider, then the result waits until taken.
// Operand errors and zero numerators skip the reduction and the
// divisions and go straight to the result.
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic [1:0]               i_cmd,
    input  wire logic [OPERAND_WIDTH-1:0] i_left_num,
    input  wire logic [OPERAND_WIDTH-1:0] i_left_den,
    input  wire logic [OPERAND_WIDTH-1:0] i_right_num,
    input  wire logic [OPERAND_WIDTH-1:0] i_right_den,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);
    t_ctrl w_ctrl;
    t_stat w_stat;

    rau_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid,
        .i_out_ready, .i_stat(w_stat), .o_ctrl(w_ctrl)
    );

    rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk, .i_ctrl(w_ctrl), .i_cmd,
        .i_ln(i_left_num), .i_ld(i_left_den),
        .i_rn(i_right_num), .i_rd(i_right_den),
        .o_stat(w_stat), .o_res(o_out)
    );

endmodule : rational_arithmetic_unit_core
`default_nettype wire

// ----- hdl/rau_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences products, sum, binary GCD reduction and the two divisions.
// ----------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state = ST_PROD;
                end
            end
            ST_PROD: begin
                o_ctrl.prod = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_ctrl.sum = 1'b1;
                n_state = ST_GCD;
            end
            ST_GCD: begin
                // Errors and zero numerators skip the reduction entirely.
                if (i_stat.bad || i_stat.num_zero) begin
                    n_state = ST_OUT;
                end else if (i_stat.gcd_done) begin
                    o_ctrl.div_start = 1'b1;
                    n_state = ST_DIVN;
                end else begin
                    o_ctrl.gcd_step = 1'b1;
                end
            end
            ST_DIVN: begin
                if (i_stat.div_done) begin
                    o_ctrl.div_start = 1'b1;
                    o_ctrl.div_den   = 1'b1;
                    n_state = ST_DIVD;
                end else begin
                    o_ctrl.div_step = 1'b1;
                end
            end
            ST_DIVD: begin
                o_ctrl.div_den = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_OUT;
                end else begin
                    o_ctrl.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid overlap");
    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> r_state == ST_PROD) else $error("load did not start");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");

endmodule : rau_ctrl
`default_nettype wire

// ----- hdl/rau_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Products, signed sum, binary GCD reduction and restoring divider.
// ----------------------------------------------------------------------------
module rau_dp
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire t_ctrl                    i_ctrl,
    input  wire logic [1:0]               i_cmd,
    input  wire logic [OPERAND_WIDTH-1:0] i_ln,
    input  wire logic [OPERAND_WIDTH-1:0] i_ld,
    input  wire logic [OPERAND_WIDTH-1:0] i_rn,
    input  wire logic [OPERAND_WIDTH-1:0] i_rd,
    output t_stat                         o_stat,
    output t_out                          o_res
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = PW + 1;
    localparam int CW = $clog2(SW + 1);

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    t_cmd r_cmd;
    logic [W-1:0] r_lnm, r_ldm, r_rnm, r_rdm;
    logic r_lns, r_lds, r_rns, r_rds;
    logic [PW-1:0] r_pa, r_pb, r_pd;
    logic r_pas, r_pbs, r_pds;
    logic [SW-1:0] r_num, r_den, r_ga, r_gb, r_rem, r_quo, r_dvd, r_g, r_qn;
    logic r_neg, r_bad;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_k;

    logic [SW:0] w_trial;
    logic [SW-1:0] w_sum_a, w_sum_b;

    assign w_sum_a = {1'b0, r_pa};
    assign w_sum_b = {1'b0, r_pb};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= t_cmd'(i_cmd);
            r_lnm <= f_mag(i_ln); r_lns <= i_ln[W-1];
            r_ldm <= f_mag(i_ld); r_lds <= i_ld[W-1];
            r_rnm <= f_mag(i_rn); r_rns <= i_rn[W-1];
            r_rdm <= f_mag(i_rd); r_rds <= i_rd[W-1];
        end
        if (i_ctrl.prod) begin
            r_bad <= (r_ldm == '0) || (r_rdm == '0)
                || (r_cmd == CMD_DIV && r_rnm == '0);
            unique case (r_cmd)
                CMD_ADD, CMD_SUB: begin
                    r_pa <= PW'(r_lnm) * PW'(r_rdm); r_pas <= r_lns ^ r_rds;
                    r_pb <= PW'(r_rnm) * PW'(r_ldm);
                    r_pbs <= r_rns ^ r_lds ^ (r_cmd == CMD_SUB);
                    r_pd <= PW'(r_ldm) * PW'(r_rdm); r_pds <= r_lds ^ r_rds;
                end
                CMD_MUL: begin
                    r_pa <= PW'(r_lnm) * PW'(r_rnm); r_pas <= r_lns ^ r_rns;
                    r_pb <= '0; r_pbs <= 1'b0;
                    r_pd <= PW'(r_ldm) * PW'(r_rdm); r_pds <= r_lds ^ r_rds;
                end
                default: begin
                    r_pa <= PW'(r_lnm) * PW'(r_rdm); r_pas <= r_lns ^ r_rds;
                    r_pb <= '0; r_pbs <= 1'b0;
                    r_pd <= PW'(r_ldm) * PW'(r_rnm); r_pds <= r_lds ^ r_rns;
                end
            endcase
        end
        if (i_ctrl.sum) begin
            // Signed-magnitude sum; the sign of a zero is don't-care here.
            if (r_pas == r_pbs) begin
                r_num <= w_sum_a + w_sum_b;
                r_ga  <= w_sum_a + w_sum_b;
                r_neg <= r_pas ^ r_pds;
            end else if (r_pa >= r_pb) begin
                r_num <= w_sum_a - w_sum_b;
                r_ga  <= w_sum_a - w_sum_b;
                r_neg <= r_pas ^ r_pds;
            end else begin
                r_num <= w_sum_b - w_sum_a;
                r_ga  <= w_sum_b - w_sum_a;
                r_neg <= r_pbs ^ r_pds;
            end
            r_den <= {1'b0, r_pd};
            r_gb  <= {1'b0, r_pd};
            r_k   <= '0;
        end
        // Binary GCD: common factors of two are counted in r_k, odd pairs
        // are reduced by subtraction. The GCD is r_gb << r_k once r_ga is zero.
        if (i_ctrl.gcd_step) begin
            priority if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_k  <= r_k + 1'b1;
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (i_ctrl.div_start) begin
            r_dvd <= i_ctrl.div_den ? r_den : r_num;
            r_g   <= i_ctrl.div_den ? r_g : (r_gb << r_k);
            r_rem <= '0;
            r_cnt <= CW'(SW);
            if (i_ctrl.div_den) r_qn <= r_quo;
        end
        if (i_ctrl.div_step) begin
            r_rem <= w_trial[SW] ? w_trial[SW-1:0] + r_g : w_trial[SW-1:0];
            r_quo <= {r_quo[SW-2:0], ~w_trial[SW]};
            r_dvd <= {r_dvd[SW-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign w_trial = {1'b0, r_rem[SW-2:0], r_dvd[SW-1]} - {1'b0, r_g};

    assign o_stat.bad      = r_bad;
    assign o_stat.num_zero = (r_num == '0);
    assign o_stat.gcd_done = (r_ga == '0);
    assign o_stat.div_done = (r_cnt == '0);

    always_comb begin
        if (r_bad) begin
            o_res = '{result_num: '0, result_den: '0, bad_operand: 1'b1};
        end else if (r_num == '0) begin
            o_res = '{result_num: '0, result_den: RES_DEN_W'(1), bad_operand: 1'b0};
        end else begin
            o_res.result_num  = r_neg ? RES_NUM_W'(~r_qn + 1'b1) : RES_NUM_W'(r_qn);
            o_res.result_den  = RES_DEN_W'(r_quo);
            o_res.bad_operand = 1'b0;
        end
    end

endmodule : rau_dp
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends fraction requests through the valid/ready input, predicts each
// reduced result in the testbench and compares it field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import rau_pkg::*;

    localparam int W          = OPERAND_WIDTH_DEF;
    localparam int N_RANDOM   = 1330;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN      = 200;

    typedef struct {
        t_cmd              cmd;
        logic signed [W-1:0] ln, ld, rn, rd;
        bit                typed;
        logic [RES_NUM_W-1:0] e_num;
        logic [RES_DEN_W-1:0] e_den;
        bit                e_bad;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_cmd;
    logic [W-1:0]       i_left_num, i_left_den, i_right_num, i_right_den;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out               o_out;

    t_out               pending_results[$];
    int                 error_count;
    int                 send_gap_pct;
    int                 recv_stall_pct;
    int                 quiet_cycles;
    bit                 in_fire;
    bit                 out_fire;
    bit                 running;

    rational_arithmetic_unit_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_left_num(i_left_num), .i_left_den(i_left_den),
        .i_right_num(i_right_num), .i_right_den(i_right_den),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Exact reduced fraction of one request; products fit easily in 64 bits.
    function automatic t_out reduce_fraction(t_cmd cmd, longint ln, longint ld,
                                             longint rn, longint rd);
        t_out   r;
        longint num, den, a, b, t;
        r = '0;
        if (ld == 0 || rd == 0 || (cmd == CMD_DIV && rn == 0)) begin
            r.bad_operand = 1'b1;
            return r;
        end
        case (cmd)
            CMD_ADD: begin num = ln * rd + rn * ld; den = ld * rd; end
            CMD_SUB: begin num = ln * rd - rn * ld; den = ld * rd; end
            CMD_MUL: begin num = ln * rn;           den = ld * rd; end
            default: begin num = ln * rd;           den = ld * rn; end
        endcase
        if (num == 0) begin
            r.result_den = RES_DEN_W'(1);
            return r;
        end
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        a = (num < 0) ? -num : num;
        b = den;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        r.result_num = RES_NUM_W'(num / a);
        r.result_den = RES_DEN_W'(den / a);
        return r;
    endfunction

    task automatic report(string what, t_out got, t_out want);
        $display("mismatch %s: got %0d/%0d bad %0b, want %0d/%0d bad %0b", what,
                 $signed(got.result_num), got.result_den, got.bad_operand,
                 $signed(want.result_num), want.result_den, want.bad_operand);
        error_count++;
    endtask

    // Receiver side: random stalls and the result check.
    always @(posedge i_clk) begin
        t_out want;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (out_fire) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", o_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out.result_num !== want.result_num)
                    report("result_num", o_out, want);
                else if (o_out.result_den !== want.result_den)
                    report("result_den", o_out, want);
                else if (o_out.bad_operand !== want.bad_operand)
                    report("bad_operand", o_out, want);
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on cycles in which neither side moves a request or result.
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (!running || in_fire || (i_rst_n && o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(t_cmd cmd, logic [W-1:0] ln, logic [W-1:0] ld,
                                logic [W-1:0] rn, logic [W-1:0] rd, t_out want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_left_num  <= ln;
        i_left_den  <= ld;
        i_right_num <= rn;
        i_right_den <= rd;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_results.push_back(want);
    endtask

    // Operand draw: mostly small magnitudes, with denominators kept in the
    // upper part of their range.
    function automatic logic [W-1:0] draw_operand(int span, bit is_den);
        int m;
        m = is_den ? $urandom_range(span / 2 + 1, span) : $urandom_range(0, span);
        if ($urandom_range(0, 1)) m = -m;
        if (span == 32768 && m == 32768) m = 32767;
        return W'(m);
    endfunction

    t_row directed[] = '{
        '{CMD_ADD, 1, 0, 1, 1, 1, 0, 0, 1},
        '{CMD_SUB, 1, 1, 1, 0, 1, 0, 0, 1},
        '{CMD_MUL, -32768, 0, 32767, 0, 1, 0, 0, 1},
        '{CMD_DIV, 5, 7, 0, 3, 1, 0, 0, 1},
        '{CMD_DIV, 0, -1, 0, -1, 1, 0, 0, 1},
        '{CMD_MUL, 0, 3, 5, 7, 1, 0, 1, 0},
        '{CMD_SUB, 3, 4, 3, 4, 1, 0, 1, 0},
        '{CMD_ADD, 1, 2, -1, 2, 1, 0, 1, 0},
        '{CMD_ADD, 1, 2, 1, 3, 1, 5, 6, 0},
        '{CMD_MUL, 2, -3, 3, 4, 1, -1, 2, 0},
        '{CMD_DIV, 1, 1, -1, 1, 1, -1, 1, 0},
        '{CMD_ADD, -32768, 32767, 32767, -32768, 0, 0, 0, 0},
        '{CMD_SUB, -32768, -32768, 32767, 32767, 0, 0, 0, 0},
        '{CMD_MUL, -32768, 32767, 32767, -32768, 0, 0, 0, 0},
        '{CMD_DIV, -32768, -32768, -32768, -32768, 0, 0, 0, 0},
        '{CMD_DIV, 32767, 32767, -32768, 32767, 0, 0, 0, 0},
        '{CMD_MUL, -1, -1, -1, -1, 0, 0, 0, 0},
        '{CMD_ADD, 21845, -21846, -10923, 10922, 0, 0, 0, 0},
        '{CMD_SUB, 12, -18, -7, 42, 0, 0, 0, 0},
        '{CMD_DIV, -9, 6, 4, -15, 0, 0, 0, 0}
    };

    initial begin
        t_out   want;
        t_row   row;
        t_cmd   cmd;
        int     span;
        logic [W-1:0] ln, ld, rn, rd;
        error_count    = 0;
        running        = 1'b0;
        send_gap_pct   = 19;
        recv_stall_pct = 46;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_out_ready <= 1'b0;
        i_cmd       <= CMD_ADD;
        i_left_num  <= '0;
        i_left_den  <= '0;
        i_right_num <= '0;
        i_right_den <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            row = directed[k];
            if (row.typed) begin
                want.result_num  = row.e_num;
                want.result_den  = row.e_den;
                want.bad_operand = row.e_bad;
            end else begin
                want = reduce_fraction(row.cmd, row.ln, row.ld, row.rn, row.rd);
            end
            send_request(row.cmd, row.ln, row.ld, row.rn, row.rd, want);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_gap_pct   = 46;
                recv_stall_pct = 19;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            // Hold off until the block has drained completely.
            if (n == N_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            case ($urandom_range(0, 19))
                0:       span = 32768;
                1, 2:    span = 4095;
                default: span = 255;
            endcase
            cmd = t_cmd'($urandom_range(0, 3));
            ln  = draw_operand(span, 1'b0);
            rn  = draw_operand(span, 1'b0);
            ld  = draw_operand(span, 1'b1);
            rd  = draw_operand(span, 1'b1);
            // Occasional zero denominators and zero divisors.
            if ($urandom_range(0, 49) == 0) ld = '0;
            if ($urandom_range(0, 49) == 0) rd = '0;
            if (cmd == CMD_DIV && $urandom_range(0, 29) == 0) rn = '0;
            want = reduce_fraction(cmd, $signed(ln), $signed(ld), $signed(rn),
                                   $signed(rd));
            send_request(cmd, ln, ld, rn, rd, want);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rau_pkg.sv
hdl/rau_ctrl.sv
hdl/rau_dp.sv
hdl/rational_arithmetic_unit_core.sv
tb/tb.sv
